### hw/rtl/mlr_pkg.sv
// Shared types and codes for the matrix line rotator.
// No dependencies; mlr_if, mlr_mod_unit and matrix_line_rotator import this package.
`default_nettype none

package mlr_pkg;

    localparam int OPCODE_W  = 2;
    localparam int INDEX_W   = 5;
    localparam int SHIFT_W   = 16;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 1;

    typedef logic [OPCODE_W-1:0]       opcode_t;
    typedef logic [INDEX_W-1:0]        index_t;
    typedef logic [SHIFT_W-1:0]        shift_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CFG_W-1:0]          cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_index_t;
    typedef logic [STATUS_W-1:0]       status_t;

    localparam opcode_t OP_WRITE   = 2'd0;
    localparam opcode_t OP_READ    = 2'd1;
    localparam opcode_t OP_ROT_ROW = 2'd2;
    localparam opcode_t OP_ROT_COL = 2'd3;

    localparam status_t STATUS_OK  = 1'b0;
    localparam status_t STATUS_BAD = 1'b1;

    localparam cfg_index_t REG_ROWS = 1'b0;
    localparam cfg_index_t REG_COLS = 1'b1;

    localparam cfg_data_t DIM_RESET = 6'd32;

endpackage

`default_nettype wire

### hw/rtl/mlr_if.sv
// Channel interfaces of the matrix line rotator: command, response, config.
// Depends on mlr_pkg for payload types.
`default_nettype none

interface mlr_cmd_if import mlr_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    index_t  line_index;
    index_t  cell_column;
    logic    toward_start;
    shift_t  shift_count;
    value_t  write_value;

    modport source (output valid, output opcode, output line_index, output cell_column,
                    output toward_start, output shift_count, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input line_index, input cell_column,
                    input toward_start, input shift_count, input write_value,
                    output ready);
endinterface

interface mlr_rsp_if import mlr_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    value_t  read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

interface mlr_cfg_if import mlr_pkg::*; ();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mlr_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the cell store and the line buffer; no package dependency.
`default_nettype none

module mlr_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] ram [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/mlr_mod_unit.sv
// Restoring remainder unit: shift count modulo line length, one bit per cycle.
// Depends on mlr_pkg for the count width.
`default_nettype none

module mlr_mod_unit import mlr_pkg::*; #(
    parameter int MAX_DIM = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire shift_t                     count,
    input  wire logic [$clog2(MAX_DIM+1)-1:0] len,
    output logic                            done,
    output logic [$clog2(MAX_DIM)-1:0]      rem
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int LEN_W = $clog2(MAX_DIM + 1);
    localparam int BIT_W = $clog2(SHIFT_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    shift_t           cnt_reg, cnt_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        trial     = {rem_reg, cnt_reg[SHIFT_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = '0;
            cnt_next  = count;
            rem_next  = '0;
            len_next  = len;
        end
        else if (busy_reg)
        begin
            // bring down the next count bit, subtract when it fits
            if (trial >= {1'b0, len_reg})
            begin
                rem_next = LEN_W'(trial - {1'b0, len_reg});
            end
            else
            begin
                rem_next = LEN_W'(trial);
            end
            cnt_next = {cnt_reg[SHIFT_W-2:0], 1'b0};
            bit_next = bit_reg + BIT_W'(1);
            if (bit_reg == BIT_W'(SHIFT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        len_reg <= len_next;
    end

    assign done = done_reg;
    assign rem  = DIM_W'(rem_reg);

endmodule

`default_nettype wire

### hw/rtl/matrix_line_rotator.sv
// Top level of the matrix line rotator: control sequencer, config registers,
// cell store, line buffer and remainder unit. Depends on mlr_pkg, mlr_if,
// mlr_ram and mlr_mod_unit.
//
//   channel | role   | word
//   --------+--------+--------------------------------------------------------
//   cmd     | sink   | opcode, line_index, cell_column, toward_start,
//           |        | shift_count, write_value
//   rsp     | source | status, read_value
//   cfg     | sink   | index (0 rows_in_use, 1 cols_in_use), data
//
// A rotation's time is set by the 16-step remainder unit and by a load
// pass and a write-back pass that each move one cell per cycle through the
// cell store. Reset sets both size registers to 32; cell contents are
// undefined until written. A finished response waits in the output
// register; the next word is taken meanwhile and its response holds until
// the output frees.
`default_nettype none

module matrix_line_rotator import mlr_pkg::*; #(
    parameter int MAX_DIM    = 32,
    parameter int CELL_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    mlr_cmd_if.sink   cmd,
    mlr_rsp_if.source rsp,
    mlr_cfg_if.sink   cfg
);

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int LEN_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = 2 * DIM_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_GAP    = 3'd4;
    localparam logic [2:0] S_STORE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    function automatic logic [LEN_W-1:0] eff_dim(input cfg_data_t v);
        logic [LEN_W-1:0] d;
        if (v == '0)
        begin
            d = LEN_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            d = LEN_W'(MAX_DIM);
        end
        else
        begin
            d = LEN_W'(v);
        end
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input logic [DIM_W-1:0] line,
                                                    input logic [DIM_W-1:0] pos,
                                                    input logic             is_col);
        return is_col ? {pos, line} : {line, pos};
    endfunction

    logic [2:0]       state_reg, state_next;
    cfg_data_t        rows_reg, rows_next;
    cfg_data_t        cols_reg, cols_next;
    logic [DIM_W-1:0] line_reg, line_next;
    logic             is_col_reg, is_col_next;
    logic             fwd_reg, fwd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [DIM_W-1:0] idx_reg, idx_next;
    logic [DIM_W-1:0] dst_reg, dst_next;
    logic             ld_pend_reg, ld_pend_next;
    logic [DIM_W-1:0] ld_dst_reg, ld_dst_next;
    logic             st_pend_reg, st_pend_next;
    logic [DIM_W-1:0] st_idx_reg, st_idx_next;
    status_t          res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;

    logic [LEN_W-1:0] nr, nc;
    logic             accept;
    logic             cell_ok, row_ok, col_ok;
    logic             idx_last, dst_last;
    logic [DIM_W-1:0] cmd_row, cmd_col;

    logic                  cell_we, cell_re;
    logic [ADDR_W-1:0]     cell_waddr, cell_raddr;
    logic [CELL_WIDTH-1:0] cell_wdata, cell_rdata;
    logic                  buf_re;
    logic [CELL_WIDTH-1:0] buf_rdata;

    logic             mod_start, mod_done;
    logic [DIM_W-1:0] mod_rem;

    assign nr      = eff_dim(rows_reg);
    assign nc      = eff_dim(cols_reg);
    assign cmd_row = DIM_W'(cmd.line_index);
    assign cmd_col = DIM_W'(cmd.cell_column);
    assign row_ok  = int'(cmd.line_index) < int'(nr);
    assign col_ok  = int'(cmd.line_index) < int'(nc);
    assign cell_ok = row_ok && (int'(cmd.cell_column) < int'(nc));

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign idx_last = (LEN_W'(idx_reg) == len_reg - LEN_W'(1));
    assign dst_last = (LEN_W'(dst_reg) == len_reg - LEN_W'(1));

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ROWS: rows_next = cfg.data;
                REG_COLS: cols_next = cfg.data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        line_next       = line_reg;
        is_col_next     = is_col_reg;
        fwd_next        = fwd_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        ld_pend_next    = 1'b0;
        ld_dst_next     = dst_reg;
        st_pend_next    = 1'b0;
        st_idx_next     = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        mod_start       = 1'b0;
        cell_re         = 1'b0;
        cell_raddr      = line_addr(line_reg, idx_reg, is_col_reg);
        cell_we         = 1'b0;
        cell_waddr      = {cmd_row, cmd_col};
        cell_wdata      = CELL_WIDTH'(cmd.write_value);
        buf_re          = 1'b0;

        // write-back pass drains into the cell store in the cycle after its read
        if (st_pend_reg)
        begin
            cell_we    = 1'b1;
            cell_waddr = line_addr(line_reg, st_idx_reg, is_col_reg);
            cell_wdata = buf_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STATUS_OK;
                    res_value_next  = '0;
                    case (cmd.opcode)
                        OP_WRITE:
                        begin
                            if (cell_ok)
                            begin
                                cell_we = 1'b1;
                            end
                            else
                            begin
                                res_status_next = STATUS_BAD;
                            end
                            state_next = S_FINISH;
                        end
                        OP_READ:
                        begin
                            if (cell_ok)
                            begin
                                cell_re    = 1'b1;
                                cell_raddr = {cmd_row, cmd_col};
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_status_next = STATUS_BAD;
                                state_next      = S_FINISH;
                            end
                        end
                        OP_ROT_ROW, OP_ROT_COL:
                        begin
                            is_col_next = (cmd.opcode == OP_ROT_COL);
                            line_next   = cmd_row;
                            fwd_next    = !cmd.toward_start;
                            len_next    = (cmd.opcode == OP_ROT_COL) ? nr : nc;
                            if ((cmd.opcode == OP_ROT_COL) ? col_ok : row_ok)
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                            else
                            begin
                                res_status_next = STATUS_BAD;
                                state_next      = S_FINISH;
                            end
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_READ:
            begin
                res_value_next = VALUE_W'(cell_rdata);
                state_next     = S_FINISH;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    idx_next = '0;
                    if (fwd_reg || (mod_rem == '0))
                    begin
                        dst_next = mod_rem;
                    end
                    else
                    begin
                        dst_next = DIM_W'(len_reg - LEN_W'(mod_rem));
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // read cell idx, park it at its rotated place in the line buffer
                cell_re      = 1'b1;
                ld_pend_next = 1'b1;
                ld_dst_next  = dst_reg;
                dst_next     = dst_last ? '0 : dst_reg + DIM_W'(1);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_GAP;
                end
                else
                begin
                    idx_next = idx_reg + DIM_W'(1);
                end
            end
            S_GAP:
            begin
                // let the last buffer write land before reading it back
                state_next = S_STORE;
            end
            S_STORE:
            begin
                buf_re       = 1'b1;
                st_pend_next = 1'b1;
                st_idx_next  = idx_reg;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + DIM_W'(1);
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= DIM_RESET;
            cols_reg      <= DIM_RESET;
            ld_pend_reg   <= 1'b0;
            st_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            ld_pend_reg   <= ld_pend_next;
            st_pend_reg   <= st_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg       <= line_next;
        is_col_reg     <= is_col_next;
        fwd_reg        <= fwd_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        dst_reg        <= dst_next;
        ld_dst_reg     <= ld_dst_next;
        st_idx_reg     <= st_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;

    mlr_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_WIDTH)
    ) u_cell_store (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mlr_ram #(
        .ADDR_W (DIM_W),
        .DATA_W (CELL_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ld_pend_reg),
        .waddr (ld_dst_reg),
        .wdata (cell_rdata),
        .re    (buf_re),
        .raddr (idx_reg),
        .rdata (buf_rdata)
    );

    mlr_mod_unit #(
        .MAX_DIM (MAX_DIM)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .count (cmd.shift_count),
        .len   (len_next),
        .done  (mod_done),
        .rem   (mod_rem)
    );

endmodule

`default_nettype wire

### sim/matrix_line_rotator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for matrix_line_rotator: random-gap driver and monitor
// around an in-bench matrix predictor. Depends on mlr_pkg and mlr_if.

module matrix_line_rotator_tb;
    import mlr_pkg::*;

    localparam int MAX_DIM         = 32;
    localparam int CELLS           = MAX_DIM * MAX_DIM;
    localparam int MODEL_PLAN      = 0;
    localparam int MODEL_CHECK     = 1;
    localparam int NUM_PHASES      = 9;
    localparam int WORDS_PER_PHASE = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 100;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        opcode_t opcode;
        index_t  line_index;
        index_t  cell_column;
        logic    toward_start;
        shift_t  shift_count;
        value_t  write_value;
    } cmd_word_t;

    typedef struct packed {
        status_t status;
        value_t  read_value;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    mlr_cmd_if cmd_ch ();
    mlr_rsp_if rsp_ch ();
    mlr_cfg_if cfg_ch ();

    matrix_line_rotator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Two copies of the matrix: one follows the words as they are queued and
    // steers stimulus away from unwritten cells, one follows accepted words.
    value_t    cell_val [2][CELLS];
    bit        cell_set [2][CELLS];
    cfg_data_t rows_reg [2];
    cfg_data_t cols_reg [2];

    cmd_word_t   cmd_backlog [$];
    rsp_word_t   expected_rsp [$];
    int unsigned words_queued;
    int unsigned words_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          steady;

    cmd_word_t   cmd_word;
    int unsigned cmd_gap;
    int unsigned rsp_stall;

    cfg_data_t phase_rows [NUM_PHASES];
    cfg_data_t phase_cols [NUM_PHASES];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int unsigned dim_used(input cfg_data_t r);
        if (r == 0)
            return 1;
        if (r > MAX_DIM)
            return MAX_DIM;
        return r;
    endfunction

    function automatic int unsigned idle_draw();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one word to matrix copy m and return the response it yields.
    function automatic rsp_word_t matrix_apply(input int m, input cmd_word_t w);
        rsp_word_t   r;
        int unsigned nr, nc, len, base, stride, k, i, src, addr;
        value_t      tmp_v [MAX_DIM];
        bit          tmp_s [MAX_DIM];
        nr = dim_used(rows_reg[m]);
        nc = dim_used(cols_reg[m]);
        r.status = STATUS_OK;
        r.read_value = '0;
        len = 0;
        base = 0;
        stride = 1;
        addr = w.line_index * MAX_DIM + w.cell_column;
        case (w.opcode)
            OP_WRITE, OP_READ:
            begin
                if (w.line_index >= nr || w.cell_column >= nc)
                    r.status = STATUS_BAD;
                else if (w.opcode == OP_WRITE)
                begin
                    cell_val[m][addr] = w.write_value;
                    cell_set[m][addr] = 1'b1;
                end
                else
                    r.read_value = cell_val[m][addr];
            end
            OP_ROT_ROW:
            begin
                if (w.line_index >= nr)
                    r.status = STATUS_BAD;
                else
                begin
                    base = w.line_index * MAX_DIM;
                    stride = 1;
                    len = nc;
                end
            end
            default:
            begin
                if (w.line_index >= nc)
                    r.status = STATUS_BAD;
                else
                begin
                    base = w.line_index;
                    stride = MAX_DIM;
                    len = nr;
                end
            end
        endcase
        if (len != 0)
        begin
            k = w.shift_count % len;
            for (i = 0; i < len; i++)
            begin
                tmp_v[i] = cell_val[m][base + i * stride];
                tmp_s[i] = cell_set[m][base + i * stride];
            end
            for (i = 0; i < len; i++)
            begin
                src = w.toward_start ? (i + k) % len : (i + len - k) % len;
                cell_val[m][base + i * stride] = tmp_v[src];
                cell_set[m][base + i * stride] = tmp_s[src];
            end
        end
        return r;
    endfunction

    // Queue one word; a read aimed at an unwritten cell moves to a written
    // one, or becomes a write when the used part holds none.
    function automatic void queue_op(input opcode_t op, input int unsigned line,
                                     input int unsigned col, input bit back,
                                     input int unsigned shift, input value_t val);
        cmd_word_t   w;
        rsp_word_t   unused;
        int unsigned nr, nc, total, start, n, idx;
        bit          found;
        nr = dim_used(rows_reg[MODEL_PLAN]);
        nc = dim_used(cols_reg[MODEL_PLAN]);
        if (op == OP_READ && line < nr && col < nc
            && !cell_set[MODEL_PLAN][line * MAX_DIM + col])
        begin
            total = nr * nc;
            start = $urandom_range(0, total - 1);
            found = 1'b0;
            for (n = 0; n < total && !found; n++)
            begin
                idx = (start + n) % total;
                if (cell_set[MODEL_PLAN][(idx / nc) * MAX_DIM + idx % nc])
                begin
                    line = idx / nc;
                    col = idx % nc;
                    found = 1'b1;
                end
            end
            if (!found)
                op = OP_WRITE;
        end
        w.opcode = op;
        w.line_index = index_t'(line);
        w.cell_column = index_t'(col);
        w.toward_start = back;
        w.shift_count = shift_t'(shift);
        w.write_value = val;
        unused = matrix_apply(MODEL_PLAN, w);
        cmd_backlog.push_back(w);
        words_queued++;
    endfunction

    function automatic void queue_random_word();
        int unsigned nr, nc, pick, line, col, shift, len;
        opcode_t     op;
        value_t      val;
        nr = dim_used(rows_reg[MODEL_PLAN]);
        nc = dim_used(cols_reg[MODEL_PLAN]);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_WRITE;
        else if (pick < 60)
            op = OP_READ;
        else if (pick < 80)
            op = OP_ROT_ROW;
        else
            op = OP_ROT_COL;
        if ($urandom_range(0, 7) == 0)
        begin
            line = $urandom_range(0, MAX_DIM - 1);
            col = $urandom_range(0, MAX_DIM - 1);
        end
        else
        begin
            line = $urandom_range(0, (op == OP_ROT_COL ? nc : nr) - 1);
            col = $urandom_range(0, nc - 1);
        end
        len = (op == OP_ROT_COL) ? nr : nc;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            shift = $urandom_range(0, 3);
        else if (pick < 6)
            shift = $urandom_range(0, 2 * len);
        else if (pick == 6)
            shift = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            shift = $urandom_range(0, 16'hFFFF);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            val = 32'sh7FFFFFFF;
        else if (pick == 1)
            val = 32'sh80000000;
        else
            val = $urandom;
        queue_op(op, line, col, 1'($urandom_range(0, 1)), shift, val);
    endfunction

    task automatic wait_drained();
        while (words_sent != words_queued || expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input cfg_data_t val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_ROWS)
        begin
            rows_reg[MODEL_PLAN]  = val;
            rows_reg[MODEL_CHECK] = val;
        end
        else
        begin
            cols_reg[MODEL_PLAN]  = val;
            cols_reg[MODEL_CHECK] = val;
        end
    endtask

    // Command driver: hold the word until taken, then draw the next gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_gap = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_rsp.push_back(matrix_apply(MODEL_CHECK, cmd_word));
                words_sent++;
                cmd_gap = idle_draw();
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cmd_word = cmd_backlog.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.opcode       <= cmd_word.opcode;
                    cmd_ch.line_index   <= cmd_word.line_index;
                    cmd_ch.cell_column  <= cmd_word.cell_column;
                    cmd_ch.toward_start <= cmd_word.toward_start;
                    cmd_ch.shift_count  <= cmd_word.shift_count;
                    cmd_ch.write_value  <= cmd_word.write_value;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor with random back-pressure.
    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status=%0d read_value=%0d",
                                 rsp_ch.status, rsp_ch.read_value);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.status !== want.status
                        || rsp_ch.read_value !== want.read_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"response mismatch: expected status=%0d ",
                                      "read_value=%0d, got status=%0d read_value=%0d"},
                                     want.status, want.read_value,
                                     rsp_ch.status, rsp_ch.read_value);
                    end
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    rsp_stall = idle_draw();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int p, n;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_WRITE;
        cmd_ch.line_index = '0;
        cmd_ch.cell_column = '0;
        cmd_ch.toward_start = 1'b0;
        cmd_ch.shift_count = '0;
        cmd_ch.write_value = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ROWS;
        cfg_ch.data = '0;
        steady = 1'b0;
        words_queued = 0;
        words_sent = 0;
        mismatches = 0;
        cycle_count = 0;
        for (p = 0; p < 2; p++)
        begin
            rows_reg[p] = DIM_RESET;
            cols_reg[p] = DIM_RESET;
        end
        phase_rows = '{6'd1, 6'd0, 6'd32, 6'd63, 6'd4, 6'd2, 6'd40, 6'd0, 6'd0};
        phase_cols = '{6'd1, 6'd7, 6'd1, 6'd63, 6'd4, 6'd32, 6'd9, 6'd0, 6'd0};
        phase_rows[7] = cfg_data_t'($urandom_range(0, 63));
        phase_cols[7] = cfg_data_t'($urandom_range(0, 63));
        phase_rows[8] = cfg_data_t'($urandom_range(0, 63));
        phase_cols[8] = cfg_data_t'($urandom_range(0, 63));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Full 32x32 after reset: corner cells, extreme values, wraparound.
        queue_op(OP_WRITE, 0, 0, 0, 0, 32'sh7FFFFFFF);
        queue_op(OP_WRITE, 31, 31, 0, 0, 32'sh80000000);
        queue_op(OP_WRITE, 0, 31, 0, 0, -32'sd1);
        queue_op(OP_WRITE, 31, 0, 0, 0, 32'sh5A5A5A5A);
        queue_op(OP_ROT_ROW, 0, 0, 0, 1, '0);
        queue_op(OP_READ, 0, 0, 0, 0, '0);
        queue_op(OP_READ, 0, 1, 0, 0, '0);
        queue_op(OP_ROT_ROW, 0, 0, 1, 16'hFFFF, '0);
        queue_op(OP_READ, 0, 2, 0, 0, '0);
        queue_op(OP_ROT_COL, 31, 0, 0, 0, '0);
        queue_op(OP_ROT_COL, 0, 0, 1, 33, '0);
        queue_op(OP_READ, 30, 0, 0, 0, '0);
        queue_op(OP_READ, 31, 31, 0, 0, '0);

        // Shrink to 2x3: out-of-range indexes and the column-up case.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_ROWS, 6'd2);
        cfg_write(REG_COLS, 6'd3);
        for (n = 0; n < 6; n++)
            queue_op(OP_WRITE, n / 3, n % 3, 0, 0, value_t'(n * 32'h11111111 - 3));
        queue_op(OP_WRITE, 2, 0, 0, 0, 32'sd99);
        queue_op(OP_READ, 0, 3, 0, 0, '0);
        queue_op(OP_ROT_ROW, 2, 0, 0, 1, '0);
        queue_op(OP_ROT_COL, 3, 0, 1, 1, '0);
        queue_op(OP_ROT_COL, 1, 0, 1, 1, '0);
        queue_op(OP_READ, 0, 1, 0, 0, '0);
        queue_op(OP_READ, 1, 1, 0, 0, '0);
        queue_op(OP_ROT_ROW, 1, 0, 0, 2, '0);
        queue_op(OP_READ, 1, 0, 0, 0, '0);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_write(REG_ROWS, phase_rows[p]);
            cfg_write(REG_COLS, phase_cols[p]);
            steady <= (p == 2 || p == 6);
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                queue_random_word();
                // starve the block once until every response is back
                if (p == 4 && n == WORDS_PER_PHASE / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
